// ===== hdl/bsdt_pkg.sv =====
// Shared types and constants for the buffered SPI display transmitter.
`timescale 1ns / 1ps

package bsdt_pkg;

  // Kind of one input item.
  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_TICK  = 1'b1
  } kind_t;

  // One byte on the serial line.
  typedef logic [7:0] byte_t;

  // Bits in one serial byte, and the bit counter type.
  typedef logic [3:0] bit_count_t;
  localparam bit_count_t BYTE_BITS = 4'd8;

  // Divider count at which the slow serial clock toggles (half period of 16 ticks).
  typedef logic [3:0] divider_t;
  localparam divider_t SLOW_LAST = 4'hF;

endpackage

// ===== hdl/bsdt_in_if.sv =====
// Input channel: byte writes and system clock ticks.
`timescale 1ns / 1ps

interface bsdt_in_if;
  logic                valid;
  logic                ready;
  bsdt_pkg::kind_t     kind;
  logic                is_data;
  bsdt_pkg::byte_t     byte_value;

  modport source (output valid, output kind, output is_data, output byte_value, input ready);
  modport sink (input valid, input kind, input is_data, input byte_value, output ready);
endinterface

// ===== hdl/bsdt_out_if.sv =====
// Output channel: pin levels and status after each input item.
`timescale 1ns / 1ps

interface bsdt_out_if #(
  parameter int LEVEL_W = 5
);
  logic               valid;
  logic               ready;
  logic               accepted;
  logic               serial_clock;
  logic               serial_data;
  logic               select_n;
  logic               data_command;
  logic               byte_done;
  logic [LEVEL_W-1:0] fifo_level;
  logic               busy_res;

  modport source (
    output valid, output accepted, output serial_clock, output serial_data,
    output select_n, output data_command, output byte_done, output fifo_level,
    output busy_res, input ready
  );
  modport sink (
    input valid, input accepted, input serial_clock, input serial_data,
    input select_n, input data_command, input byte_done, input fifo_level,
    input busy_res, output ready
  );
endinterface

// ===== hdl/buffered_spi_display_transmitter.sv =====
// Write-only SPI master with a transmit FIFO and a data/command line.
//
//   Channel   Direction  Handshake          Contents
//   in_ch     sink       valid / ready      kind, is_data, byte_value
//   out_ch    source     valid / ready      pin levels, accepted, byte_done, level, busy
//   cfg       write      cfg_write          fast_clock in bit 0 of cfg_data
//
// One item per cycle is sustained while results drain.
// Each transfer updates the shifter and FIFO at once and loads the result register.
// The FIFO head is held in a registered read port that is refetched every cycle.
// rst is synchronous and active high; the FIFO contents are not cleared.
// A new item is taken when the result register is empty or is being read out.
`timescale 1ns / 1ps

module buffered_spi_display_transmitter #(
  parameter int FIFO_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_data,
  bsdt_in_if.sink    in_ch,
  bsdt_out_if.source out_ch
);

  localparam int PTR_W   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int LEVEL_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [PTR_W-1:0]   LAST_PTR = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [LEVEL_W-1:0] FULL     = LEVEL_W'(FIFO_DEPTH);

  // Configuration register.
  logic fast_clock;

  // FIFO storage and its registered head read.
  logic [8:0]         fifo_mem [FIFO_DEPTH];
  logic [8:0]         head;
  logic [PTR_W-1:0]   read_pointer, read_pointer_next;
  logic [PTR_W-1:0]   write_pointer, write_pointer_next;
  logic [LEVEL_W-1:0] fill_count, fill_count_next;
  logic               push;

  // Serial shifter state.
  bsdt_pkg::byte_t      shift_byte, shift_byte_next;
  bsdt_pkg::bit_count_t bits_left, bits_left_next;
  bsdt_pkg::divider_t   divider_count, divider_count_next;
  logic clock_level, clock_level_next;
  logic select_level, select_level_next;
  logic dc_level, dc_level_next;
  logic shifting, shifting_next;
  logic gap_pending, gap_pending_next;

  // Per-item results.
  logic accepted_now;
  logic done_now;
  logic transfer;
  logic out_valid;
  bsdt_pkg::bit_count_t bits_dec;

  assign in_ch.ready  = !out_valid || out_ch.ready;
  assign transfer     = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid;
  assign bits_dec     = (bits_left != '0) ? bits_left - 4'd1 : bits_left;

  // Next state for one input item.
  always_comb begin
    read_pointer_next  = read_pointer;
    write_pointer_next = write_pointer;
    fill_count_next    = fill_count;
    shift_byte_next    = shift_byte;
    bits_left_next     = bits_left;
    divider_count_next = divider_count;
    clock_level_next   = clock_level;
    select_level_next  = select_level;
    dc_level_next      = dc_level;
    shifting_next      = shifting;
    gap_pending_next   = gap_pending;
    push               = 1'b0;
    accepted_now       = 1'b0;
    done_now           = 1'b0;

    if (transfer) begin
      if (in_ch.kind == bsdt_pkg::KIND_WRITE) begin
        if (!shifting && !gap_pending && fill_count == '0) begin
          // Idle: start the byte directly.
          shift_byte_next    = in_ch.byte_value;
          dc_level_next      = in_ch.is_data;
          bits_left_next     = bsdt_pkg::BYTE_BITS;
          divider_count_next = '0;
          clock_level_next   = 1'b1;
          select_level_next  = 1'b0;
          shifting_next      = 1'b1;
          gap_pending_next   = 1'b0;
          accepted_now       = 1'b1;
        end else if (fill_count != FULL) begin
          // Queue behind the bytes already waiting.
          push               = 1'b1;
          write_pointer_next = (write_pointer == LAST_PTR) ? '0 : write_pointer + PTR_W'(1);
          fill_count_next    = fill_count + LEVEL_W'(1);
          accepted_now       = 1'b1;
        end
      end else if (!shifting) begin
        // Tick between bytes: close the gap and start the oldest queued byte, if any.
        gap_pending_next = 1'b0;
        if (fill_count != '0) begin
          read_pointer_next  = (read_pointer == LAST_PTR) ? '0 : read_pointer + PTR_W'(1);
          fill_count_next    = fill_count - LEVEL_W'(1);
          shift_byte_next    = head[7:0];
          dc_level_next      = head[8];
          bits_left_next     = bsdt_pkg::BYTE_BITS;
          divider_count_next = '0;
          clock_level_next   = 1'b1;
          select_level_next  = 1'b0;
          shifting_next      = 1'b1;
        end
      end else if (fast_clock || divider_count == bsdt_pkg::SLOW_LAST) begin
        // Half period over: toggle the serial clock.
        divider_count_next = '0;
        if (clock_level) begin
          clock_level_next = 1'b0;
          if (bits_left < bsdt_pkg::BYTE_BITS) begin
            shift_byte_next = {shift_byte[6:0], 1'b0};
          end
        end else begin
          clock_level_next = 1'b1;
          bits_left_next   = bits_dec;
          if (bits_dec == '0) begin
            done_now          = 1'b1;
            shifting_next     = 1'b0;
            gap_pending_next  = 1'b1;
            select_level_next = 1'b1;
          end
        end
      end else begin
        divider_count_next = divider_count + 4'd1;
      end
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      fast_clock <= 1'b0;
    end else if (cfg_write) begin
      fast_clock <= cfg_data;
    end
  end

  // Control state of the FIFO and the shifter.
  always_ff @(posedge clk) begin
    if (rst) begin
      read_pointer  <= '0;
      write_pointer <= '0;
      fill_count    <= '0;
      shift_byte    <= '0;
      bits_left     <= '0;
      divider_count <= '0;
      clock_level   <= 1'b1;
      select_level  <= 1'b1;
      dc_level      <= 1'b0;
      shifting      <= 1'b0;
      gap_pending   <= 1'b0;
    end else begin
      read_pointer  <= read_pointer_next;
      write_pointer <= write_pointer_next;
      fill_count    <= fill_count_next;
      shift_byte    <= shift_byte_next;
      bits_left     <= bits_left_next;
      divider_count <= divider_count_next;
      clock_level   <= clock_level_next;
      select_level  <= select_level_next;
      dc_level      <= dc_level_next;
      shifting      <= shifting_next;
      gap_pending   <= gap_pending_next;
    end
  end

  // FIFO write port.
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[write_pointer] <= {in_ch.is_data, in_ch.byte_value};
    end
  end

  // Head read at the next read pointer, with a write into that entry forwarded.
  always_ff @(posedge clk) begin
    if (push && write_pointer == read_pointer_next) begin
      head <= {in_ch.is_data, in_ch.byte_value};
    end else begin
      head <= fifo_mem[read_pointer_next];
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (transfer) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload, loaded with the levels after the item.
  always_ff @(posedge clk) begin
    if (transfer) begin
      out_ch.accepted     <= accepted_now;
      out_ch.serial_clock <= clock_level_next;
      out_ch.serial_data  <= shift_byte_next[7];
      out_ch.select_n     <= select_level_next;
      out_ch.data_command <= dc_level_next;
      out_ch.byte_done    <= done_now;
      out_ch.fifo_level   <= fill_count_next;
      out_ch.busy_res     <= shifting_next || gap_pending_next || (fill_count_next != '0);
    end
  end

endmodule

// ===== hdl/bsdt_checker.sv =====
// Port-level checks for the buffered SPI display transmitter, and their binding.
`timescale 1ns / 1ps

module bsdt_checker #(
  parameter int LEVEL_W = 5
) (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic               accepted,
  input logic               serial_clock,
  input logic               select_n,
  input logic               byte_done,
  input logic [LEVEL_W-1:0] fifo_level,
  input logic               busy_res
);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before its transfer");

  // The serial clock only goes low inside a selected byte.
  a_clock_select: assert property (@(posedge clk) disable iff (rst)
    out_valid && !serial_clock |-> !select_n)
    else $error("serial clock low while deselected");

  // A finished byte leaves the clock high, deselects, and is never a write result.
  a_done_levels: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_done |-> serial_clock && select_n && !accepted)
    else $error("bad pin levels at end of byte");

  // Queued bytes keep the transmitter busy.
  a_level_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && fifo_level != '0 |-> busy_res)
    else $error("bytes queued while reported idle");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result offered right after reset");

endmodule

bind buffered_spi_display_transmitter bsdt_checker #(
  .LEVEL_W(LEVEL_W)
) u_bsdt_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .accepted     (out_ch.accepted),
  .serial_clock (out_ch.serial_clock),
  .select_n     (out_ch.select_n),
  .byte_done    (out_ch.byte_done),
  .fifo_level   (out_ch.fifo_level),
  .busy_res     (out_ch.busy_res)
);

// ===== verif/tb_buffered_spi_display_transmitter.sv =====
// Testbench for the buffered SPI display transmitter: directed rows with set or predicted pins, random items predicted.
`timescale 1ns / 1ps

module tb_buffered_spi_display_transmitter;

  localparam int TX_DEPTH    = 16;
  localparam int TX_PTR_W    = $clog2(TX_DEPTH);
  localparam int TX_LEVEL_W  = $clog2(TX_DEPTH + 1);
  localparam int CYCLE_LIMIT = 400000;

  // Pin levels and status after one input item.
  typedef struct packed {
    logic                  accepted;
    logic                  sclk;
    logic                  sdata;
    logic                  sel_n;
    logic                  dc;
    logic                  done;
    logic [TX_LEVEL_W-1:0] level;
    logic                  busy;
  } spi_pins_t;

  // One row of the directed stimulus.
  typedef struct {
    bsdt_pkg::kind_t kind;
    logic            is_data;
    bsdt_pkg::byte_t value;
    bit              typed;
    spi_pins_t       want;
  } stim_row_t;

  logic clk;
  logic rst;
  logic cfg_write;
  logic cfg_data;

  bsdt_in_if  in_ch ();
  bsdt_out_if #(.LEVEL_W(TX_LEVEL_W)) out_ch ();

  buffered_spi_display_transmitter #(
    .FIFO_DEPTH(TX_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // Predictor state: FIFO, shifter and pin levels.
  logic [8:0]            tx_queue [TX_DEPTH];
  logic [TX_PTR_W-1:0]   tx_rd_ptr;
  logic [TX_PTR_W-1:0]   tx_wr_ptr;
  logic [TX_LEVEL_W-1:0] tx_fill;
  bsdt_pkg::byte_t       tx_shift;
  bsdt_pkg::bit_count_t  tx_bits_left;
  bsdt_pkg::divider_t    tx_div;
  logic                  tx_sclk;
  logic                  tx_sel_n;
  logic                  tx_dc;
  logic                  tx_active;
  logic                  tx_gap;
  logic                  tx_fast;

  spi_pins_t expected_pins [$];
  stim_row_t directed_rows [$];
  int        errors;
  int        cycles;
  int        stall_left;
  bit        in_gaps_on;
  bit        out_stalls_on;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic spi_pins_t pin_state(logic acc, logic sclk, logic sdata, logic sel_n,
                                          logic dc, logic done,
                                          logic [TX_LEVEL_W-1:0] level, logic busy);
    return {acc, sclk, sdata, sel_n, dc, done, level, busy};
  endfunction

  // Gap length: mostly none, some short, a few long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void load_shifter(bsdt_pkg::byte_t value, logic dc);
    tx_shift     = value;
    tx_dc        = dc;
    tx_bits_left = bsdt_pkg::BYTE_BITS;
    tx_div       = '0;
    tx_sclk      = 1'b1;
    tx_sel_n     = 1'b0;
    tx_active    = 1'b1;
    tx_gap       = 1'b0;
  endfunction

  // Applies one write or tick to the predictor and returns the pins after it.
  function automatic spi_pins_t advance_transmitter(bsdt_pkg::kind_t kind, logic is_data,
                                                    bsdt_pkg::byte_t value);
    spi_pins_t          res;
    logic [8:0]         entry;
    bsdt_pkg::divider_t half_last;
    res = '0;
    half_last = tx_fast ? bsdt_pkg::divider_t'(0) : bsdt_pkg::SLOW_LAST;
    if (kind == bsdt_pkg::KIND_WRITE) begin
      if (!tx_active && !tx_gap && tx_fill == 0) begin
        load_shifter(value, is_data);
        res.accepted = 1'b1;
      end else if (tx_fill < TX_DEPTH) begin
        tx_queue[tx_wr_ptr] = {is_data, value};
        tx_wr_ptr = (tx_wr_ptr == TX_PTR_W'(TX_DEPTH - 1)) ? '0 : tx_wr_ptr + TX_PTR_W'(1);
        tx_fill = tx_fill + TX_LEVEL_W'(1);
        res.accepted = 1'b1;
      end
    end else if (!tx_active) begin
      // Idle tick: the gap ends and the oldest queued byte, if any, starts.
      tx_gap = 1'b0;
      if (tx_fill > 0) begin
        entry = tx_queue[tx_rd_ptr];
        tx_rd_ptr = (tx_rd_ptr == TX_PTR_W'(TX_DEPTH - 1)) ? '0 : tx_rd_ptr + TX_PTR_W'(1);
        tx_fill = tx_fill - TX_LEVEL_W'(1);
        load_shifter(entry[7:0], entry[8]);
      end
    end else if (tx_div >= half_last) begin
      tx_div = '0;
      if (tx_sclk) begin
        // Falling edge: the next bit moves up, except before the first bit.
        tx_sclk = 1'b0;
        if (tx_bits_left < bsdt_pkg::BYTE_BITS) tx_shift = tx_shift << 1;
      end else begin
        tx_sclk = 1'b1;
        if (tx_bits_left > 0) tx_bits_left = tx_bits_left - 4'd1;
        if (tx_bits_left == 0) begin
          res.done  = 1'b1;
          tx_active = 1'b0;
          tx_gap    = 1'b1;
          tx_sel_n  = 1'b1;
        end
      end
    end else begin
      tx_div = tx_div + 4'd1;
    end
    res.sclk  = tx_sclk;
    res.sdata = tx_shift[7];
    res.sel_n = tx_sel_n;
    res.dc    = tx_dc;
    res.level = tx_fill;
    res.busy  = tx_active || tx_gap || tx_fill > 0;
    return res;
  endfunction

  function automatic void add_row(bsdt_pkg::kind_t kind, logic is_data, bsdt_pkg::byte_t value,
                                  bit typed, spi_pins_t want);
    stim_row_t row;
    row.kind    = kind;
    row.is_data = is_data;
    row.value   = value;
    row.typed   = typed;
    row.want    = want;
    directed_rows.push_back(row);
  endfunction

  // Offers one item, waits for its transfer, and records the expected pins.
  task automatic drive_item(bsdt_pkg::kind_t kind, logic is_data, bsdt_pkg::byte_t value,
                            bit typed, spi_pins_t want);
    int        gap;
    spi_pins_t predicted;
    gap = in_gaps_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= kind;
    in_ch.is_data    <= is_data;
    in_ch.byte_value <= value;
    do @(posedge clk); while (!in_ch.ready);
    predicted = advance_transmitter(kind, is_data, value);
    expected_pins.push_back(typed ? want : predicted);
  endtask

  // Drops valid and waits until every result has come back.
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_pins.size() != 0) @(posedge clk);
  endtask

  task automatic write_speed(logic fast);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= fast;
    @(negedge clk);
    cfg_write <= 1'b0;
    tx_fast = fast;
  endtask

  task automatic report_field(string name, logic [TX_LEVEL_W-1:0] want,
                              logic [TX_LEVEL_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Result sink: random stalls, released at the falling edge.
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      out_ch.ready <= 1'b1;
      if (out_stalls_on) stall_left = pick_gap();
    end
  end

  // Each result transfer is compared with the oldest expectation.
  always @(posedge clk) begin
    spi_pins_t got;
    spi_pins_t want;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = {out_ch.accepted, out_ch.serial_clock, out_ch.serial_data, out_ch.select_n,
             out_ch.data_command, out_ch.byte_done, out_ch.fifo_level, out_ch.busy_res};
      if (expected_pins.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %0h", $time, got);
        errors++;
      end else begin
        want = expected_pins.pop_front();
        report_field("accepted", TX_LEVEL_W'(want.accepted), TX_LEVEL_W'(got.accepted));
        report_field("serial_clock", TX_LEVEL_W'(want.sclk), TX_LEVEL_W'(got.sclk));
        report_field("serial_data", TX_LEVEL_W'(want.sdata), TX_LEVEL_W'(got.sdata));
        report_field("select_n", TX_LEVEL_W'(want.sel_n), TX_LEVEL_W'(got.sel_n));
        report_field("data_command", TX_LEVEL_W'(want.dc), TX_LEVEL_W'(got.dc));
        report_field("byte_done", TX_LEVEL_W'(want.done), TX_LEVEL_W'(got.done));
        report_field("fifo_level", want.level, got.level);
        report_field("busy_res", TX_LEVEL_W'(want.busy), TX_LEVEL_W'(got.busy));
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[buffered_spi_display_transmitter] ERROR");
    $finish;
  end

  // Main sequence: reset, directed rows, then random phases at both speeds.
  initial begin
    bsdt_pkg::byte_t fill_bytes [15];
    logic            speed_plan [9];
    int              count;
    int              write_odds;
    int              burst_left;
    bsdt_pkg::kind_t kind;
    stim_row_t       row;

    rst              = 1'b1;
    cfg_write        = 1'b0;
    cfg_data         = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.kind       = bsdt_pkg::KIND_TICK;
    in_ch.is_data    = 1'b0;
    in_ch.byte_value = '0;
    in_gaps_on       = 1'b1;
    out_stalls_on    = 1'b1;

    // Predictor reset.
    tx_rd_ptr    = '0;
    tx_wr_ptr    = '0;
    tx_fill      = '0;
    tx_shift     = '0;
    tx_bits_left = '0;
    tx_div       = '0;
    tx_sclk      = 1'b1;
    tx_sel_n     = 1'b1;
    tx_dc        = 1'b0;
    tx_active    = 1'b0;
    tx_gap       = 1'b0;
    tx_fast      = 1'b0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Idle tick, a direct start, then the FIFO filled to the brim and overrun.
    fill_bytes = '{8'h80, 8'h01, 8'h7F, 8'hFE, 8'hAA, 8'h55, 8'h00, 8'hFF,
                   8'hC3, 8'h3C, 8'h10, 8'h08, 8'hE7, 8'h5A, 8'hA5};
    add_row(bsdt_pkg::KIND_TICK, 1'b0, 8'h00, 1'b1,
            pin_state(1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, '0, 1'b0));
    add_row(bsdt_pkg::KIND_WRITE, 1'b1, 8'hFF, 1'b1,
            pin_state(1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, '0, 1'b1));
    add_row(bsdt_pkg::KIND_WRITE, 1'b0, 8'h00, 1'b1,
            pin_state(1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, TX_LEVEL_W'(1), 1'b1));
    for (int i = 0; i < TX_DEPTH - 1; i++)
      add_row(bsdt_pkg::KIND_WRITE, i[0], fill_bytes[i % 15], 1'b0, '0);
    add_row(bsdt_pkg::KIND_WRITE, 1'b1, 8'h5A, 1'b1,
            pin_state(1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, TX_LEVEL_W'(TX_DEPTH), 1'b1));
    add_row(bsdt_pkg::KIND_TICK, 1'b1, 8'hFF, 1'b0, '0);
    add_row(bsdt_pkg::KIND_WRITE, 1'b0, 8'hFF, 1'b1,
            pin_state(1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, TX_LEVEL_W'(TX_DEPTH), 1'b1));

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      drive_item(row.kind, row.is_data, row.value, row.typed, row.want);
    end
    drain_results();

    // Random phases; state carries over, so speed changes land mid-byte.
    speed_plan = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
    foreach (speed_plan[p]) begin
      write_speed(speed_plan[p]);
      in_gaps_on    = $urandom_range(0, 3) != 0;
      out_stalls_on = $urandom_range(0, 3) != 0;
      count         = speed_plan[p] ? 100 : 200;
      write_odds    = speed_plan[p] ? 5 : 60;
      burst_left    = ($urandom_range(0, 2) == 0) ? $urandom_range(4, 20) : 0;
      for (int n = 0; n < count; n++) begin
        if (burst_left == 0 && $urandom_range(0, 99) == 0)
          burst_left = $urandom_range(4, 20);
        if (burst_left > 0) begin
          burst_left--;
          kind = bsdt_pkg::KIND_WRITE;
        end else begin
          kind = ($urandom_range(0, write_odds) == 0) ? bsdt_pkg::KIND_WRITE
                                                       : bsdt_pkg::KIND_TICK;
        end
        drive_item(kind, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0, '0);
      end
      drain_results();
    end

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("[buffered_spi_display_transmitter] OK");
    end else begin
      $display("[buffered_spi_display_transmitter] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/bsdt_pkg.sv
hdl/bsdt_in_if.sv
hdl/bsdt_out_if.sv
hdl/buffered_spi_display_transmitter.sv
hdl/bsdt_checker.sv
verif/tb_buffered_spi_display_transmitter.sv
